FILE: src/fmpa_pkg.sv
// ----------------------------------------------------------------------------
// fmpa_pkg
// Shared types and constants of the frame motion and presence analyser.
// ----------------------------------------------------------------------------
package fmpa_pkg;

  localparam int MAX_SAMPLES_D   = 4096;
  localparam int MAX_DIMENSION_D = 4096;
  localparam int GRID_TARGET_D   = 48;

  localparam logic [15:0] CONF_LOW  = 16'd13107;
  localparam logic [15:0] CONF_HIGH = 16'd52429;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BTHR   = 3'd2;
  localparam logic [2:0] REG_MTHR   = 3'd3;
  localparam logic [2:0] REG_DTHR   = 3'd4;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_req_t;

  typedef struct packed {
    logic [15:0]        mean_brightness;
    logic [15:0]        motion_score;
    logic               motion_compared;
    logic               presence;
    logic               centroid_valid;
    logic signed [15:0] centroid_x;
    logic signed [15:0] centroid_y;
    logic [15:0]        confidence;
    logic [12:0]        sample_count;
  } out_req_t;

  // frame totals handed from front to back
  typedef struct packed {
    logic [20:0] bsum;
    logic [20:0] dsum;
    logic [20:0] wsum;
    logic [32:0] xsum;
    logic [32:0] ysum;
    logic [16:0] scount;
    logic [13:0] wdim;
    logic [13:0] hdim;
    logic [7:0]  bthr;
    logic [15:0] mthr;
    logic        compared;
  } frame_tot_t;

endpackage

FILE: src/fmpa_front.sv
// ----------------------------------------------------------------------------
// fmpa_front
// Pixel intake: grid sampling, luma, difference and accumulation.
// ----------------------------------------------------------------------------
module fmpa_front import fmpa_pkg::*; #(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_D,
  parameter int MAX_DIMENSION = MAX_DIMENSION_D,
  parameter int GRID_TARGET   = GRID_TARGET_D
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_data,
  input  logic       cfg_clear,
  input  logic [12:0] frame_width,
  input  logic [12:0] frame_height,
  input  logic [7:0]  brightness_threshold,
  input  logic [15:0] motion_threshold,
  input  logic [7:0]  diff_threshold,
  output logic       tot_valid,
  input  logic       tot_ready,
  output frame_tot_t tot_data
);

  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int DW = $clog2(MAX_DIMENSION + 1);
  // grid step by reciprocal multiplication
  localparam int RSH = 26;
  localparam longint unsigned RCP = ((64'd1 << RSH) + GRID_TARGET - 1) / GRID_TARGET;

  logic [DW-1:0] wdim, hdim, mindim, step, sq;
  logic [DW+RSH:0] sprod;
  logic [DW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DW-1:0] cph_r, cph_nxt, rph_r, rph_nxt;
  logic [SW:0]   sidx_r, sidx_nxt;
  logic [20:0]   bsum_r, bsum_nxt, dsum_r, dsum_nxt, wsum_r, wsum_nxt;
  logic [32:0]   xsum_r, xsum_nxt, ysum_r, ysum_nxt;
  logic          pvalid_r, pvalid_nxt;
  // stage 1 registers (sample pending memory read)
  logic          s1_v_r;
  logic [7:0]    s1_luma_r;
  logic [DW-1:0] s1_col_r, s1_row_r;
  logic          s1_last_r;
  logic [7:0]    mem [MAX_SAMPLES];
  logic [7:0]    prev_q;
  logic          take, is_sample, is_last, hold_r, hold_nxt;
  logic [7:0]    luma, d;
  logic [12:0]   lsum;
  frame_tot_t    tot_r, tot_nxt;
  logic          tot_v_r, tot_v_nxt;

  function automatic logic [DW-1:0] eff(input logic [12:0] v);
    logic [DW-1:0] r;
    if (v == 13'd0) r = DW'(1);
    else if (32'(v) > MAX_DIMENSION) r = DW'(MAX_DIMENSION);
    else r = DW'(v);
    return r;
  endfunction

  assign wdim   = eff(frame_width);
  assign hdim   = eff(frame_height);
  assign mindim = (wdim < hdim) ? wdim : hdim;
  assign sprod  = (DW+RSH+1)'(mindim) * (DW+RSH+1)'(RCP);
  assign sq     = sprod[RSH +: DW];
  assign step   = (sq == '0) ? DW'(1) : sq;

  // a frame end waits while the previous totals are unclaimed
  assign in_ready  = !hold_r && !cfg_clear;
  assign take      = in_valid && in_ready;
  assign is_sample = (cph_r == '0) && (rph_r == '0) && (32'(sidx_r) < MAX_SAMPLES);
  assign is_last   = (col_r + 1'b1 >= wdim) && (row_r + 1'b1 >= hdim);
  assign lsum = {5'b0, in_data.pixel_red} * 13'd11 + {5'b0, in_data.pixel_green} * 13'd16
              + {5'b0, in_data.pixel_blue} * 13'd5;
  assign luma = lsum[12:5];

  always_ff @(posedge clk) begin
    if (take && is_sample) begin
      mem[sidx_r[SW-1:0]] <= luma;
      prev_q <= mem[sidx_r[SW-1:0]];
    end
    s1_luma_r <= luma;
    s1_col_r  <= col_r;
    s1_row_r  <= row_r;
    tot_r     <= tot_nxt;
  end

  assign d = (s1_luma_r >= prev_q) ? s1_luma_r - prev_q : prev_q - s1_luma_r;

  always_comb begin
    col_nxt = col_r; row_nxt = row_r; cph_nxt = cph_r; rph_nxt = rph_r;
    sidx_nxt = sidx_r; hold_nxt = hold_r;
    bsum_nxt = bsum_r; dsum_nxt = dsum_r; wsum_nxt = wsum_r;
    xsum_nxt = xsum_r; ysum_nxt = ysum_r; pvalid_nxt = pvalid_r;
    tot_nxt = tot_r; tot_v_nxt = tot_v_r;
    if (tot_v_r && tot_ready) tot_v_nxt = 1'b0;
    if (take) begin
      if (is_sample) sidx_nxt = sidx_r + 1'b1;
      if (col_r + 1'b1 < wdim) begin
        col_nxt = col_r + 1'b1;
        cph_nxt = (cph_r + 1'b1 == step) ? '0 : cph_r + 1'b1;
      end else begin
        col_nxt = '0; cph_nxt = '0;
        if (row_r + 1'b1 < hdim) begin
          row_nxt = row_r + 1'b1;
          rph_nxt = (rph_r + 1'b1 == step) ? '0 : rph_r + 1'b1;
        end else begin
          row_nxt = '0; rph_nxt = '0; hold_nxt = 1'b1;
        end
      end
    end
    if (s1_v_r) begin
      bsum_nxt = bsum_r + 21'(s1_luma_r);
      if (pvalid_r) begin
        dsum_nxt = dsum_r + 21'(d);
        if (d >= diff_threshold) begin
          wsum_nxt = wsum_r + 21'(d);
          xsum_nxt = xsum_r + 33'(32'(s1_col_r) * 32'(d));
          ysum_nxt = ysum_r + 33'(32'(s1_row_r) * 32'(d));
        end
      end
    end
    if (s1_last_r) begin
      if (!tot_v_r || tot_ready) begin
        tot_nxt.bsum = bsum_nxt; tot_nxt.dsum = dsum_nxt; tot_nxt.wsum = wsum_nxt;
        tot_nxt.xsum = xsum_nxt; tot_nxt.ysum = ysum_nxt;
        tot_nxt.scount = (sidx_r == '0) ? 17'd1 : 17'(sidx_r);
        tot_nxt.wdim = 14'(wdim); tot_nxt.hdim = 14'(hdim);
        tot_nxt.bthr = brightness_threshold; tot_nxt.mthr = motion_threshold;
        tot_nxt.compared = pvalid_r;
        tot_v_nxt = 1'b1;
        bsum_nxt = '0; dsum_nxt = '0; wsum_nxt = '0; xsum_nxt = '0; ysum_nxt = '0;
        sidx_nxt = '0; pvalid_nxt = 1'b1; hold_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      col_r <= '0; row_r <= '0; cph_r <= '0; rph_r <= '0; sidx_r <= '0;
      bsum_r <= '0; dsum_r <= '0; wsum_r <= '0; xsum_r <= '0; ysum_r <= '0;
      pvalid_r <= 1'b0; s1_v_r <= 1'b0; s1_last_r <= 1'b0; hold_r <= 1'b0;
      if (!rst_n) tot_v_r <= 1'b0;
      else tot_v_r <= tot_v_nxt;
    end else begin
      col_r <= col_nxt; row_r <= row_nxt; cph_r <= cph_nxt; rph_r <= rph_nxt;
      sidx_r <= sidx_nxt; bsum_r <= bsum_nxt; dsum_r <= dsum_nxt; wsum_r <= wsum_nxt;
      xsum_r <= xsum_nxt; ysum_r <= ysum_nxt; pvalid_r <= pvalid_nxt;
      hold_r <= hold_nxt; tot_v_r <= tot_v_nxt;
      // no request is taken while a frame end is pending
      s1_v_r <= take && is_sample;
      if (take && is_last) s1_last_r <= 1'b1;
      else if (s1_last_r && (!tot_v_r || tot_ready)) s1_last_r <= 1'b0;
    end
  end

  assign tot_valid = tot_v_r;
  assign tot_data  = tot_r;

endmodule

FILE: src/fmpa_div.sv
// ----------------------------------------------------------------------------
// fmpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmpa_div import fmpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [54:0] num,
  input  logic [54:0] den,
  output logic        done,
  output logic [54:0] quo
);

  logic [54:0] q_r, q_nxt, rem_r, rem_nxt, den_r;
  logic [55:0] trial;
  logic [5:0]  cnt_r;
  logic        busy_r;

  assign trial = {rem_r, q_r[54]};

  always_comb begin
    q_nxt = {q_r[53:0], 1'b0};
    rem_nxt = trial[54:0];
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = 55'(trial - {1'b0, den_r});
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1; cnt_r <= 6'd55; q_r <= num; rem_r <= '0; den_r <= den;
      done <= 1'b0;
    end else if (busy_r) begin
      q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_r - 1'b1;
      done <= (cnt_r == 6'd1);
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end

  assign quo = q_r;

endmodule

FILE: src/fmpa_back.sv
// ----------------------------------------------------------------------------
// fmpa_back
// Frame-end arithmetic: means, presence, centroids and confidence.
// ----------------------------------------------------------------------------
module fmpa_back import fmpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tot_valid,
  output logic       tot_ready,
  input  frame_tot_t tot_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_req_t   out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_CMP = 7'b0000010, S_BM = 7'b0000100, S_MM = 7'b0001000,
    S_CX = 7'b0010000, S_CY = 7'b0100000, S_CF = 7'b1000000
  } st_t;

  st_t         st_r;
  frame_tot_t  t_r;
  out_req_t    o_r;
  logic        ov_r, pres_r, started_r;
  logic        dstart, ddone;
  logic [54:0] dnum, dden, dquo;
  logic [31:0] pb, pm;
  logic [13:0] mx, my;

  fmpa_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                  .done(ddone), .quo(dquo));

  assign tot_ready = (st_r == S_IDLE) && !ov_r;
  assign mx = (t_r.wdim > 14'd1) ? t_r.wdim - 14'd1 : 14'd1;
  assign my = (t_r.hdim > 14'd1) ? t_r.hdim - 14'd1 : 14'd1;

  always_comb begin
    dnum = '0; dden = 55'd1;
    unique case (st_r)
      S_BM: begin dnum = 55'(t_r.bsum) << 8; dden = 55'(t_r.scount); end
      S_MM: begin dnum = 55'(t_r.dsum) << 8; dden = 55'(t_r.scount); end
      S_CX: begin dnum = 55'(t_r.xsum) << 16; dden = 55'(t_r.wsum) * 55'(mx); end
      S_CY: begin dnum = 55'(t_r.ysum) << 16; dden = 55'(t_r.wsum) * 55'(my); end
      S_CF: begin dnum = 55'(t_r.dsum) << 16; dden = 55'(t_r.scount) * 55'd18; end
      default: ;
    endcase
  end
  assign dstart = !started_r && (st_r != S_IDLE) && (st_r != S_CMP);

  function automatic logic [15:0] sat15(input logic [54:0] q);
    logic [15:0] r;
    if (q >= 55'd65535) r = 16'h7fff;
    else r = 16'(q[15:0] - 16'h8000);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    pb <= 32'(t_r.bthr) * 32'(t_r.scount);
    pm <= 32'(t_r.mthr) * 32'(t_r.scount);
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; started_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (dstart) started_r <= 1'b1;
      unique case (st_r)
        S_IDLE: if (tot_valid && tot_ready) begin
          t_r <= tot_data; st_r <= S_CMP; started_r <= 1'b1;
        end
        S_CMP: begin
          if (started_r) started_r <= 1'b0;
          else begin
            pres_r <= (32'(t_r.bsum) >= pb) && ({t_r.dsum, 8'd0} >= 29'(pm));
            st_r <= S_BM;
          end
        end
        S_BM: if (ddone) begin
          o_r.mean_brightness <= dquo[15:0]; st_r <= S_MM; started_r <= 1'b0;
        end
        S_MM: if (ddone) begin
          o_r.motion_score <= dquo[15:0]; st_r <= S_CX; started_r <= 1'b0;
        end
        S_CX: if (ddone) begin
          o_r.centroid_x <= (t_r.wsum != '0) ? sat15(dquo) : 16'sd0;
          st_r <= S_CY; started_r <= 1'b0;
        end
        S_CY: if (ddone) begin
          o_r.centroid_y <= (t_r.wsum != '0) ? sat15(dquo) : 16'sd0;
          st_r <= S_CF; started_r <= 1'b0;
        end
        S_CF: if (ddone) begin
          if (!pres_r) o_r.confidence <= '0;
          else if (dquo < 55'(CONF_LOW)) o_r.confidence <= CONF_LOW;
          else if (dquo > 55'(CONF_HIGH)) o_r.confidence <= CONF_HIGH;
          else o_r.confidence <= dquo[15:0];
          o_r.motion_compared <= t_r.compared;
          o_r.presence <= pres_r;
          o_r.centroid_valid <= (t_r.wsum != '0);
          o_r.sample_count <= t_r.scount[12:0];
          ov_r <= 1'b1; st_r <= S_IDLE; started_r <= 1'b0;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data  = o_r;

endmodule

FILE: src/frame_motion_presence_analyzer_top.sv
// ----------------------------------------------------------------------------
// frame_motion_presence_analyzer_top
// Frame-difference motion, brightness and presence analyser.
//
//   channel | direction | handshake
//   in_     | request   | in_valid / in_ready
//   out_    | result    | out_valid / out_ready
//   cfg_    | write     | cfg_we
//
// One pixel per cycle while in_ready is high; after the last pixel of a frame the
// input idles while the totals pass to the frame-end unit, and longer while the
// totals of the previous frame are still held. The frame-end unit computes the
// report by five serial divisions after it takes the totals, and it takes new
// totals once the report is accepted. Synchronous reset; no clearing pass. A
// write to any of the five registers restarts the frame.
// ----------------------------------------------------------------------------
module frame_motion_presence_analyzer_top import fmpa_pkg::*; #(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_D,
  parameter int MAX_DIMENSION = MAX_DIMENSION_D,
  parameter int GRID_TARGET   = GRID_TARGET_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_req_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [12:0] fw_r, fh_r;
  logic [7:0]  bt_r, dt_r;
  logic [15:0] mt_r;
  logic        clr;
  logic        tot_valid, tot_ready;
  frame_tot_t  tot_data;

  assign clr = cfg_we && (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_BTHR, REG_MTHR,
                                            REG_DTHR});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 13'd640; fh_r <= 13'd480; bt_r <= 8'd25; mt_r <= 16'd512; dt_r <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  fw_r <= cfg_data[12:0];
        REG_HEIGHT: fh_r <= cfg_data[12:0];
        REG_BTHR:   bt_r <= cfg_data[7:0];
        REG_MTHR:   mt_r <= cfg_data;
        REG_DTHR:   dt_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fmpa_front #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_DIMENSION(MAX_DIMENSION),
               .GRID_TARGET(GRID_TARGET)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cfg_clear(clr),
    .frame_width(fw_r), .frame_height(fh_r), .brightness_threshold(bt_r),
    .motion_threshold(mt_r), .diff_threshold(dt_r),
    .tot_valid, .tot_ready, .tot_data);

  fmpa_back u_back (.clk, .rst_n, .tot_valid, .tot_ready, .tot_data,
                    .out_valid, .out_ready, .out_data);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sample_count != 13'd0) else $error("zero count");
  a_cent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.centroid_valid |-> out_data.centroid_x == 16'sd0)
    else $error("centroid");

endmodule
